### src/ghtd_pkg.sv
// ---------------------------------------------------------------------------
// ghtd_pkg: shared types and constants for the heading/turn decision block
// Beat payloads, turn codes, register indexes and the arctangent table.
// ---------------------------------------------------------------------------
`default_nettype none
package ghtd_pkg;

  typedef struct packed {
    logic signed [31:0] here_first_coord;
    logic signed [31:0] here_second_coord;
    logic signed [15:0] body_east;
    logic signed [15:0] body_north;
    logic signed [15:0] yaw;
  } in_t;

  typedef struct packed {
    logic signed [15:0] rotate_angle;
    logic [1:0]         turn_command;
    logic [31:0]        goal_distance;
  } out_t;

  localparam logic [1:0] CMD_STOP = 2'd0;
  localparam logic [1:0] CMD_CCW  = 2'd1;
  localparam logic [1:0] CMD_CW   = 2'd2;

  localparam logic [1:0] REG_TGT_FIRST  = 2'd0;
  localparam logic [1:0] REG_TGT_SECOND = 2'd1;
  localparam logic [1:0] REG_DEADBAND   = 2'd2;

  localparam int VEC_W = 50;   // dot / cross width
  localparam int CRD_W = 54;   // CORDIC datapath width
  localparam int Z_W   = 34;   // angle accumulator, degrees * 2^23

  localparam logic signed [Z_W-1:0] HALF_TURN_Z = 34'sd1509949440;
  localparam logic signed [15:0]    ANG_LIMIT   = 16'sd23040;

  typedef struct packed {
    logic                    v;
    logic                    zero;
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic signed [Z_W-1:0]   z;
    logic signed [15:0]      yaw;
  } cstage_t;

  typedef struct packed {
    logic        v;
    logic        sat;
    logic [63:0] rem;
    logic [63:0] root;
  } sqstage_t;

  // atan(2^-i) in degrees * 2^23, rounded
  function automatic logic signed [Z_W-1:0] atan_z(input int i);
    logic signed [Z_W-1:0] r;
    case (i)
      0:  r = 34'sd377487360;
      1:  r = 34'sd222843801;
      2:  r = 34'sd117744544;
      3:  r = 34'sd59768969;
      4:  r = 34'sd30000467;
      5:  r = 34'sd15014858;
      6:  r = 34'sd7509261;
      7:  r = 34'sd3754860;
      8:  r = 34'sd1877459;
      9:  r = 34'sd938733;
      10: r = 34'sd469367;
      11: r = 34'sd234683;
      12: r = 34'sd117342;
      13: r = 34'sd58671;
      14: r = 34'sd29335;
      15: r = 34'sd14668;
      16: r = 34'sd7334;
      17: r = 34'sd3667;
      18: r = 34'sd1833;
      19: r = 34'sd917;
      20: r = 34'sd458;
      21: r = 34'sd229;
      22: r = 34'sd115;
      23: r = 34'sd57;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### src/ghtd_isqrt.sv
// ---------------------------------------------------------------------------
// ghtd_isqrt: pipelined integer square root
// One result bit per stage, 32 stages; saturation flag rides along.
// ---------------------------------------------------------------------------
`default_nettype none
module ghtd_isqrt
  import ghtd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_sat,
  input  wire logic [63:0] radicand,
  output logic             out_valid,
  output logic [31:0]      root
);

  localparam int STEPS = 32;

  sqstage_t pipe [0:STEPS];

  always_comb begin
    pipe[0].v    = in_valid;
    pipe[0].sat  = in_sat;
    pipe[0].rem  = radicand;
    pipe[0].root = '0;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic [63:0] trial;
    assign trial = pipe[i].root + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        pipe[i+1].v <= 1'b0;
      end else begin
        pipe[i+1].v <= pipe[i].v;
      end
      pipe[i+1].sat <= pipe[i].sat;
      if (pipe[i].rem >= trial) begin
        pipe[i+1].rem  <= pipe[i].rem - trial;
        pipe[i+1].root <= (pipe[i].root >> 1) + BIT;
      end else begin
        pipe[i+1].rem  <= pipe[i].rem;
        pipe[i+1].root <= pipe[i].root >> 1;
      end
    end
  end

  assign out_valid = pipe[STEPS].v;
  assign root      = pipe[STEPS].sat ? 32'hFFFF_FFFF : pipe[STEPS].root[31:0];

endmodule
`default_nettype wire

### src/ghtd_cordic.sv
// ---------------------------------------------------------------------------
// ghtd_cordic: pipelined atan2 by CORDIC vectoring
// Normalize, fold into the right half plane, one stage per iteration, round.
// ---------------------------------------------------------------------------
`default_nettype none
module ghtd_cordic
  import ghtd_pkg::*;
#(
  parameter int ITERATIONS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  input  wire logic signed [VEC_W-1:0] x_in,
  input  wire logic signed [VEC_W-1:0] y_in,
  input  wire logic signed [15:0]      yaw_in,
  output logic                         out_valid,
  output logic signed [15:0]           angle,
  output logic signed [15:0]           yaw_out
);

  // stage 1: magnitude leading one -> shift count
  logic [VEC_W-2:0] ax, ay, mag;
  logic [5:0]       msb;
  logic             v1, zero1;
  logic signed [VEC_W-1:0] x1, y1;
  logic signed [15:0] yaw1;
  logic [5:0]       k1;

  always_comb begin
    ax  = x_in[VEC_W-1] ? (VEC_W-1)'(-x_in) : x_in[VEC_W-2:0];
    ay  = y_in[VEC_W-1] ? (VEC_W-1)'(-y_in) : y_in[VEC_W-2:0];
    mag = (ay > ax) ? ay : ax;
    msb = '0;
    for (int i = 0; i < VEC_W - 1; i++) begin
      if (mag[i]) msb = 6'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    x1    <= x_in;
    y1    <= y_in;
    yaw1  <= yaw_in;
    zero1 <= (x_in == '0) && (y_in == '0);
    k1    <= (msb >= 6'd46) ? 6'd0 : 6'd46 - msb;
  end

  // stage 2: scale so the larger magnitude reaches 2^46
  logic v2, zero2;
  logic signed [VEC_W:0] x2, y2;
  logic signed [15:0] yaw2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    x2    <= {x1[VEC_W-1], x1} <<< k1;
    y2    <= {y1[VEC_W-1], y1} <<< k1;
    yaw2  <= yaw1;
    zero2 <= zero1;
  end

  // stage 3: half-turn fold, feeds the iteration chain
  cstage_t pipe [0:ITERATIONS];
  logic signed [CRD_W-1:0] x2e, y2e;
  assign x2e = CRD_W'(x2);
  assign y2e = CRD_W'(y2);

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe[0].v <= 1'b0;
    end else begin
      pipe[0].v <= v2;
    end
    pipe[0].zero <= zero2;
    pipe[0].yaw  <= yaw2;
    if (x2 < 0) begin
      pipe[0].x <= -x2e;
      pipe[0].y <= -y2e;
      pipe[0].z <= (y2 >= 0) ? HALF_TURN_Z : -HALF_TURN_Z;
    end else begin
      pipe[0].x <= x2e;
      pipe[0].y <= y2e;
      pipe[0].z <= '0;
    end
  end

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    localparam logic signed [Z_W-1:0] ATAN = atan_z(i);
    logic signed [CRD_W-1:0] xs, ys;
    assign xs = pipe[i].x >>> i;
    assign ys = pipe[i].y >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        pipe[i+1].v <= 1'b0;
      end else begin
        pipe[i+1].v <= pipe[i].v;
      end
      pipe[i+1].zero <= pipe[i].zero;
      pipe[i+1].yaw  <= pipe[i].yaw;
      if (pipe[i].y >= 0) begin
        pipe[i+1].x <= pipe[i].x + ys;
        pipe[i+1].y <= pipe[i].y - xs;
        pipe[i+1].z <= pipe[i].z + ATAN;
      end else begin
        pipe[i+1].x <= pipe[i].x - ys;
        pipe[i+1].y <= pipe[i].y + xs;
        pipe[i+1].z <= pipe[i].z - ATAN;
      end
    end
  end

  // round to degrees*128, half up, then clamp
  logic signed [Z_W-1:0] zr;
  logic signed [Z_W-17:0] r;
  logic signed [15:0] ang_next;

  always_comb begin
    zr = (pipe[ITERATIONS].z + Z_W'(32768)) >>> 16;
    r  = zr[Z_W-17:0];
    if (pipe[ITERATIONS].zero) begin
      ang_next = '0;
    end else if (r > (Z_W-16)'(ANG_LIMIT)) begin
      ang_next = ANG_LIMIT;
    end else if (r < -(Z_W-16)'(ANG_LIMIT)) begin
      ang_next = -ANG_LIMIT;
    end else begin
      ang_next = r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= pipe[ITERATIONS].v;
    end
    angle   <= ang_next;
    yaw_out <= pipe[ITERATIONS].yaw;
  end

endmodule
`default_nettype wire

### src/gps_heading_turn_decision.sv
// ---------------------------------------------------------------------------
// gps_heading_turn_decision: distance, bearing error and bang-bang turn
// Path: done rises after the difference, product and sum stages, the 32-stage
// square root and the result register, which loads result together with done.
// Throughput: one fix per cycle. busy stays low and the receiver cannot stall.
// Reset (rst, synchronous): pipeline empties, targets 0, deadband 256.
// ---------------------------------------------------------------------------
`default_nettype none
module gps_heading_turn_decision
  import ghtd_pkg::*;
#(
  parameter int ANGLE_ITERATIONS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire in_t         in_item,
  output logic             done,
  output out_t             result,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int PAD = 28 - ANGLE_ITERATIONS;

  logic signed [31:0] tgt_first, tgt_second;
  logic [14:0]        deadband;

  always_ff @(posedge clk) begin
    if (rst) begin
      tgt_first  <= '0;
      tgt_second <= '0;
      deadband   <= 15'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TGT_FIRST:  tgt_first  <= cfg_data;
        REG_TGT_SECOND: tgt_second <= cfg_data;
        REG_DEADBAND:   deadband   <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 0: difference vector
  logic v0;
  logic signed [32:0] dx0, dy0;
  logic signed [15:0] be0, bn0, yaw0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
    dx0  <= {tgt_first[31], tgt_first} -
            {in_item.here_first_coord[31], in_item.here_first_coord};
    dy0  <= {tgt_second[31], tgt_second} -
            {in_item.here_second_coord[31], in_item.here_second_coord};
    be0  <= in_item.body_east;
    bn0  <= in_item.body_north;
    yaw0 <= in_item.yaw;
  end

  // stage 1: products and squares
  logic v1, sat1;
  logic signed [48:0] p_xe, p_yn, p_xn, p_ye;
  logic [63:0] sqx1, sqy1;
  logic signed [15:0] yaw1;
  logic [32:0] adx, ady;

  assign adx = dx0[32] ? 33'(-dx0) : dx0;
  assign ady = dy0[32] ? 33'(-dy0) : dy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    p_xe <= dx0 * be0;
    p_yn <= dy0 * bn0;
    p_xn <= dx0 * bn0;
    p_ye <= dy0 * be0;
    sqx1 <= adx[31:0] * adx[31:0];
    sqy1 <= ady[31:0] * ady[31:0];
    sat1 <= adx[32] || ady[32];
    yaw1 <= yaw0;
  end

  // stage 2: dot, cross, sum of squares
  logic v2, sat2;
  logic signed [VEC_W-1:0] dot2, crs2;
  logic [63:0] rad2;
  logic [64:0] sum1;
  logic signed [15:0] yaw2;

  assign sum1 = {1'b0, sqx1} + {1'b0, sqy1};

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    dot2 <= {p_xe[48], p_xe} + {p_yn[48], p_yn};
    crs2 <= {p_xn[48], p_xn} - {p_ye[48], p_ye};
    rad2 <= sum1[63:0];
    sat2 <= sat1 || sum1[64];
    yaw2 <= yaw1;
  end

  logic        sq_valid;
  logic [31:0] goal_dist;

  ghtd_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_sat    (sat2),
    .radicand  (rad2),
    .out_valid (sq_valid),
    .root      (goal_dist)
  );

  logic               an_valid;
  logic signed [15:0] ang, an_yaw;

  ghtd_cordic #(
    .ITERATIONS (ANGLE_ITERATIONS)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .x_in      (dot2),
    .y_in      (crs2),
    .yaw_in    (yaw2),
    .out_valid (an_valid),
    .angle     (ang),
    .yaw_out   (an_yaw)
  );

  // align the angle path with the square root
  logic signed [15:0] ang_d [0:PAD];
  logic signed [15:0] yaw_d [0:PAD];
  logic               vld_d [0:PAD];

  assign ang_d[0] = ang;
  assign yaw_d[0] = an_yaw;
  assign vld_d[0] = an_valid;

  for (genvar i = 0; i < PAD; i++) begin : g_pad
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_d[i+1] <= 1'b0;
      end else begin
        vld_d[i+1] <= vld_d[i];
      end
      ang_d[i+1] <= ang_d[i];
      yaw_d[i+1] <= yaw_d[i];
    end
  end

  // turn decision and result beat
  logic signed [16:0] s_sum, db_s;
  logic [1:0]         cmd;

  always_comb begin
    s_sum = {yaw_d[PAD][15], yaw_d[PAD]} + {ang_d[PAD][15], ang_d[PAD]};
    db_s  = {2'b00, deadband};
    if (s_sum > db_s) begin
      cmd = CMD_CCW;
    end else if (s_sum < -db_s) begin
      cmd = CMD_CW;
    end else begin
      cmd = CMD_STOP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sq_valid && vld_d[PAD];
    end
    result.rotate_angle  <= ang_d[PAD];
    result.turn_command  <= cmd;
    result.goal_distance <= goal_dist;
  end

endmodule
`default_nettype wire
